// ===== rtl/hdlc_deframer_crc16_check_defines.svh =====
// Assertion macros shared by the deframer checker.
// Depends on signals named clk and rst_n in the scope of use.
`ifndef HDLC_DEFRAMER_CRC16_CHECK_DEFINES_SVH
`define HDLC_DEFRAMER_CRC16_CHECK_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HDCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HDCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hdcc_pkg.sv =====
// Shared types, framing constants and the CRC-16/X.25 byte update.
// No dependencies.
package hdcc_pkg;

    localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
    localparam logic [7:0]  ESC_BYTE   = 8'h7D;
    localparam logic [7:0]  ESC_XOR    = 8'h20;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_XOROUT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h8408;

    typedef logic [1:0] status_t;
    typedef logic       kind_t;

    localparam status_t ST_GOOD   = 2'd0;
    localparam status_t ST_SHORT  = 2'd1;
    localparam status_t ST_BADCRC = 2'd2;

    localparam kind_t KIND_DATA = 1'b0;
    localparam kind_t KIND_END  = 1'b1;

    // Reflected CRC, one bit per step, eight steps per byte.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== rtl/hdcc_in_if.sv =====
// Input channel: raw received bytes with valid/ready.
// Depends on nothing but the clock domain of its users.
interface hdcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/hdcc_out_if.sv =====
// Result channel: decoded bytes and frame-end status with valid/ready.
// Depends on hdcc_pkg for the kind and status types.
interface hdcc_out_if;
    logic               valid;
    logic               ready;
    hdcc_pkg::kind_t    kind;
    logic [7:0]         data_byte;
    hdcc_pkg::status_t  frame_status;

    modport source (output valid, output kind, output data_byte, output frame_status,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input frame_status,
                    output ready);
endinterface

// ===== rtl/hdlc_deframer_crc16_check.sv =====
// Async HDLC deframer with CRC-16/X.25 frame check, top level.
// Depends on hdcc_pkg, hdcc_in_if and hdcc_out_if.
//
//  channel  | dir | payload                              | role
//  ---------+-----+--------------------------------------+---------------------------
//  rx_ch    | in  | rx_byte[7:0]                         | raw escaped byte stream
//  res_ch   | out | kind, data_byte[7:0], frame_status   | decoded byte / frame end
//
// One byte per cycle while rx_ch.ready is high; the result of a transaction appears in the
// result register in the cycle after it is accepted. The CRC byte update is the longest path in that cycle.
// An escape byte produces no result. rx_ch.ready drops only while a result waits
// and res_ch.ready is low. Reset (rst_n low) clears the frame state and drops res_ch.valid.
module hdlc_deframer_crc16_check (
    input  logic          clk,
    input  logic          rst_n,
    hdcc_in_if.sink       rx_ch,
    hdcc_out_if.source    res_ch
);

    logic        esc_reg,   esc_next;
    logic [15:0] crc_reg,   crc_next;
    logic [7:0]  held0_reg, held0_next;
    logic [7:0]  held1_reg, held1_next;
    logic [1:0]  count_reg, count_next;

    logic               res_valid_reg, res_valid_next;
    hdcc_pkg::kind_t    kind_reg,      kind_next;
    logic [7:0]         data_reg,      data_next;
    hdcc_pkg::status_t  status_reg,    status_next;

    logic        accept;
    logic        is_flag;
    logic        esc_start;
    logic        has_result;
    logic [7:0]  decoded;
    logic [15:0] fcs;
    hdcc_pkg::status_t end_status;

    assign rx_ch.ready = !res_valid_reg || res_ch.ready;
    assign accept      = rx_ch.valid && rx_ch.ready;

    assign is_flag    = (rx_ch.rx_byte == hdcc_pkg::FLAG_BYTE);
    assign esc_start  = !is_flag && !esc_reg && (rx_ch.rx_byte == hdcc_pkg::ESC_BYTE);
    assign has_result = !esc_start;
    assign decoded    = esc_reg ? (rx_ch.rx_byte ^ hdcc_pkg::ESC_XOR) : rx_ch.rx_byte;
    assign fcs        = {held1_reg, held0_reg};

    always_comb
    begin
        if (count_reg <= 2'd2)
            end_status = hdcc_pkg::ST_SHORT;
        else if ((crc_reg ^ hdcc_pkg::CRC_XOROUT) == fcs)
            end_status = hdcc_pkg::ST_GOOD;
        else
            end_status = hdcc_pkg::ST_BADCRC;
    end

    always_comb
    begin
        esc_next   = esc_reg;
        crc_next   = crc_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        count_next = count_reg;
        if (accept)
        begin
            priority if (is_flag)
            begin
                // Flag ends the frame, dropping any pending escape.
                esc_next   = 1'b0;
                crc_next   = hdcc_pkg::CRC_INIT;
                held0_next = 8'h00;
                held1_next = 8'h00;
                count_next = 2'd0;
            end
            else if (esc_start)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                esc_next = 1'b0;
                // Advance the hold; the oldest byte leaves into the CRC.
                if (count_reg >= 2'd2)
                    crc_next = hdcc_pkg::crc_byte(crc_reg, held0_reg);
                held0_next = held1_reg;
                held1_next = decoded;
                if (count_reg != 2'd3)
                    count_next = count_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && !res_ch.ready;
        kind_next      = kind_reg;
        data_next      = data_reg;
        status_next    = status_reg;
        if (accept && has_result)
        begin
            res_valid_next = 1'b1;
            if (is_flag)
            begin
                kind_next   = hdcc_pkg::KIND_END;
                data_next   = 8'h00;
                status_next = end_status;
            end
            else
            begin
                kind_next   = hdcc_pkg::KIND_DATA;
                data_next   = decoded;
                status_next = hdcc_pkg::ST_GOOD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg       <= 1'b0;
            crc_reg       <= hdcc_pkg::CRC_INIT;
            held0_reg     <= 8'h00;
            held1_reg     <= 8'h00;
            count_reg     <= 2'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            esc_reg       <= esc_next;
            crc_reg       <= crc_next;
            held0_reg     <= held0_next;
            held1_reg     <= held1_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload, no reset needed.
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        data_reg   <= data_next;
        status_reg <= status_next;
    end

    assign res_ch.valid        = res_valid_reg;
    assign res_ch.kind         = kind_reg;
    assign res_ch.data_byte    = data_reg;
    assign res_ch.frame_status = status_reg;

endmodule

// ===== rtl/hdcc_checker.sv =====
// Port-level checks for the deframer, bound to the top level.
// Depends on hdcc_pkg and hdlc_deframer_crc16_check_defines.svh.
`include "hdlc_deframer_crc16_check_defines.svh"

module hdcc_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    input  logic               rx_ready,
    input  logic [7:0]         rx_byte,
    input  logic               res_valid,
    input  logic               res_ready,
    input  hdcc_pkg::kind_t    kind,
    input  logic [7:0]         data_byte,
    input  hdcc_pkg::status_t  frame_status
);

    // Hold a stalled result transaction.
    `HDCC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable({kind, data_byte, frame_status}), "stalled result changed")

    // A flag transaction always yields a frame-end result in the next cycle.
    `HDCC_ASSERT_NEXT(a_flag_end, rx_valid && rx_ready && (rx_byte == hdcc_pkg::FLAG_BYTE), res_valid && (kind == hdcc_pkg::KIND_END), "flag without frame end")

    `HDCC_ASSERT_NOW(a_end_fields, res_valid && (kind == hdcc_pkg::KIND_END), (data_byte == 8'h00) && (frame_status != 2'd3), "bad frame-end fields")

    `HDCC_ASSERT_NOW(a_data_fields, res_valid && (kind == hdcc_pkg::KIND_DATA), frame_status == hdcc_pkg::ST_GOOD, "data result with status")

endmodule

bind hdlc_deframer_crc16_check hdcc_checker u_hdcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_valid     (rx_ch.valid),
    .rx_ready     (rx_ch.ready),
    .rx_byte      (rx_ch.rx_byte),
    .res_valid    (res_ch.valid),
    .res_ready    (res_ch.ready),
    .kind         (res_ch.kind),
    .data_byte    (res_ch.data_byte),
    .frame_status (res_ch.frame_status)
);
